>>> src/fca_pkg.sv
// Shared types and constants of the allocation table block.
// Used by fca_dir, fat_chain_allocator_unit and the testbench. No dependencies.
package fca_pkg;

	localparam int DIR_ENTRIES_DEF = 16;
	localparam int DISK_BLOCKS_DEF = 256;

	localparam int OP_W   = 3;
	localparam int KEY_W  = 64;
	localparam int BLK_W  = 8;
	localparam int LEN_W  = 13;
	localparam int ST_W   = 3;
	localparam int TB_W   = 7;
	localparam int CFG_W  = 13;

	localparam logic [TB_W-1:0]  TABLE_BLOCKS_RST = 7'd11;
	localparam logic [LEN_W-1:0] BLOCK_SIZE_RST   = 13'd128;

	localparam logic REG_TABLE_BLOCKS = 1'b0;
	localparam logic REG_BLOCK_SIZE   = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_FORMAT = 3'd0,
		OP_CREATE = 3'd1,
		OP_REMOVE = 3'd2,
		OP_APPEND = 3'd3,
		OP_UNLINK = 3'd4,
		OP_CHECK  = 3'd5,
		OP_NEXT   = 3'd6,
		OP_FIRST  = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_DIR_FULL  = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_NOT_EMPTY = 3'd4,
		ST_BAD_LEN   = 3'd5,
		ST_NOT_OWNED = 3'd6,
		ST_DISK_FULL = 3'd7
	} status_t;

	// Directory write controls from the sequencer.
	typedef struct packed {
		logic wr;       // write key and first block, set valid
		logic inval;    // clear the valid bit of one entry
		logic clr_all;  // clear every valid bit
	} dir_ctl_t;

endpackage

>>> src/fca_dir.sv
// Directory of named files: valid flops plus key and first-block memories.
// Depends on fca_pkg for the control struct and key width.
module fca_dir #(
	parameter int DIR_ENTRIES = fca_pkg::DIR_ENTRIES_DEF,
	parameter int DW = 4,
	parameter int AW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fca_pkg::dir_ctl_t          ctl,
	input  logic [DW-1:0]              waddr,
	input  logic [fca_pkg::KEY_W-1:0]  wkey,
	input  logic [AW-1:0]              wfirst,
	input  logic [DW-1:0]              raddr,
	output logic                       rvalid,
	output logic [fca_pkg::KEY_W-1:0]  rkey,
	output logic [AW-1:0]              rfirst
);

	logic [DIR_ENTRIES-1:0]       valid_q;
	logic [fca_pkg::KEY_W-1:0]    key_mem [DIR_ENTRIES];
	logic [AW-1:0]                first_mem [DIR_ENTRIES];
	logic                         rvalid_q;
	logic [fca_pkg::KEY_W-1:0]    rkey_q;
	logic [AW-1:0]                rfirst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr_all) begin
			valid_q <= '0;
		end else if (ctl.wr) begin
			valid_q[waddr] <= 1'b1;
		end else if (ctl.inval) begin
			valid_q[waddr] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			key_mem[waddr]   <= wkey;
			first_mem[waddr] <= wfirst;
		end
		rkey_q   <= key_mem[raddr];
		rfirst_q <= first_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[raddr];
		end
	end

	assign rvalid = rvalid_q;
	assign rkey   = rkey_q;
	assign rfirst = rfirst_q;

endmodule

>>> src/fca_table.sv
// Allocation table memory: one write and one registered read per cycle.
// Reads return zero before the first format and beyond the disk. Uses no package items.
module fca_table #(
	parameter int DISK_BLOCKS = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fmt_set,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	localparam logic [AW:0] DB_C = (AW+1)'(DISK_BLOCKS);

	logic [AW-1:0] mem [DISK_BLOCKS];
	logic [AW-1:0] q_q;
	logic          fmt_q;
	logic          zero_q;

	always_ff @(posedge clk) begin
		if (we && ({1'b0, waddr} < DB_C)) begin
			mem[waddr] <= wdata;
		end
		q_q <= mem[raddr];
	end

	// The table holds no meaning until the first format has written every entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= 1'b0;
			zero_q <= 1'b1;
		end else begin
			if (fmt_set) begin
				fmt_q <= 1'b1;
			end
			zero_q <= !fmt_q || ({1'b0, raddr} >= DB_C);
		end
	end

	assign rdata = zero_q ? '0 : q_q;

endmodule

>>> src/fat_chain_allocator_unit.sv
// Top level: sequencer that walks the directory and the allocation table chains.
// Depends on fca_pkg, fca_dir and fca_table.
//
// Channel   Signals                                           Handshake
// input     operation, file_key, block_index, data_length     start & !busy
// result    status, block_result, last_block                  done, one cycle
// config    cfg_index, cfg_wdata                              cfg_we
//
// A bad length is answered straight from idle, without busy rising.
// Format writes one table entry a cycle, from entry 0 up to the last block.
// Lookups read the directory one entry at a time; chain walks read the table one block
// at a time, bounded by the single table read port.
// After reset the table reads as empty until the first format; no clearing pass.
// The result is shown for one cycle as busy falls; the receiver cannot stall.
module fat_chain_allocator_unit #(
	parameter int DIR_ENTRIES = fca_pkg::DIR_ENTRIES_DEF,
	parameter int DISK_BLOCKS = fca_pkg::DISK_BLOCKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [fca_pkg::OP_W-1:0]   operation,
	input  logic [fca_pkg::KEY_W-1:0]  file_key,
	input  logic [fca_pkg::BLK_W-1:0]  block_index,
	input  logic [fca_pkg::LEN_W-1:0]  data_length,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [fca_pkg::CFG_W-1:0]  cfg_wdata,
	output logic                       done,
	output logic [fca_pkg::ST_W-1:0]   status,
	output logic [fca_pkg::BLK_W-1:0]  block_result,
	output logic                       last_block
);

	localparam int AW = $clog2(DISK_BLOCKS);
	localparam int NW = AW + 1;
	localparam int CW = ((AW > fca_pkg::BLK_W) ? AW : fca_pkg::BLK_W) + 1;
	localparam int DW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
	localparam logic [CW-1:0] DB_C   = CW'(DISK_BLOCKS);
	localparam logic [AW-1:0] LAST_I = AW'(DISK_BLOCKS - 1);
	localparam logic [NW-1:0] N_MAX  = NW'(DISK_BLOCKS);
	localparam logic [DW-1:0] LAST_D = DW'(DIR_ENTRIES - 1);

	typedef enum logic [18:0] {
		S_IDLE  = 19'h00001,
		S_FMT   = 19'h00002,
		S_DRD   = 19'h00004,
		S_DCMP  = 19'h00008,
		S_DISP  = 19'h00010,
		S_HRD   = 19'h00020,
		S_HGOT  = 19'h00040,
		S_NGOT  = 19'h00080,
		S_ACLR  = 19'h00100,
		S_DWR   = 19'h00200,
		S_WRD   = 19'h00400,
		S_WGOT  = 19'h00800,
		S_LINK  = 19'h01000,
		S_OWN   = 19'h02000,
		S_OGOT  = 19'h04000,
		S_BGOT  = 19'h08000,
		S_URD   = 19'h10000,
		S_UGOT  = 19'h20000,
		S_UHEAD = 19'h40000
	} state_t;

	state_t state_q;

	logic [fca_pkg::TB_W-1:0]  tb_q;
	logic [fca_pkg::LEN_W-1:0] bs_q;

	fca_pkg::op_t              op_q;
	logic [fca_pkg::KEY_W-1:0] key_q;
	logic [fca_pkg::BLK_W-1:0] blk_q;

	logic [AW-1:0] i_q;
	logic [DW-1:0] idx_q;
	logic [DW-1:0] fidx_q;
	logic [DW-1:0] free_q;
	logic          found_q;
	logic          freef_q;
	logic [AW-1:0] first_q;
	logic [AW-1:0] b_q;
	logic [NW-1:0] n_q;
	logic [AW-1:0] alloc_q;
	logic [AW-1:0] nb_q;

	logic                      done_q;
	logic [fca_pkg::ST_W-1:0]  status_q;
	logic [fca_pkg::BLK_W-1:0] result_q;
	logic                      last_q;

	logic          t_we;
	logic [AW-1:0] t_waddr;
	logic [AW-1:0] t_wdata;
	logic [AW-1:0] t_raddr;
	logic [AW-1:0] t_rdata;
	logic          fmt_set;

	fca_pkg::dir_ctl_t         dctl;
	logic [DW-1:0]             d_waddr;
	logic [AW-1:0]             d_wfirst;
	logic                      d_rvalid;
	logic [fca_pkg::KEY_W-1:0] d_rkey;
	logic [AW-1:0]             d_rfirst;

	logic [CW-1:0] start_c;
	logic [CW-1:0] i_c;
	logic [AW-1:0] fmt_val;
	logic [AW-1:0] wval;
	logic [CW-1:0] blk_c;
	logic [CW-1:0] tgt_c;
	logic          blk_bad;

	fca_dir #(
		.DIR_ENTRIES(DIR_ENTRIES),
		.DW(DW),
		.AW(AW)
	) u_dir (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(dctl),
		.waddr(d_waddr),
		.wkey(key_q),
		.wfirst(d_wfirst),
		.raddr(idx_q),
		.rvalid(d_rvalid),
		.rkey(d_rkey),
		.rfirst(d_rfirst)
	);

	fca_table #(
		.DISK_BLOCKS(DISK_BLOCKS),
		.AW(AW)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.fmt_set(fmt_set),
		.we(t_we),
		.waddr(t_waddr),
		.wdata(t_wdata),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	// Format links blocks past the reserved area in ascending order.
	always_comb begin
		start_c = CW'(tb_q) + CW'(2);
		i_c     = CW'(i_q);
		if (i_q == '0) begin
			fmt_val = (start_c < DB_C) ? AW'(start_c) : '0;
		end else if (i_c < start_c) begin
			fmt_val = AW'(1);
		end else begin
			fmt_val = ((i_c + CW'(1)) < DB_C) ? AW'(i_c + CW'(1)) : '0;
		end
	end

	assign wval    = (op_q == fca_pkg::OP_APPEND) ? alloc_q : nb_q;
	assign blk_c   = CW'(blk_q);
	assign tgt_c   = (op_q == fca_pkg::OP_APPEND) ? '0 : blk_c;
	assign blk_bad = (blk_q == '0) || (blk_c >= DB_C);

	always_comb begin
		t_we     = 1'b0;
		t_waddr  = b_q;
		t_wdata  = wval;
		t_raddr  = b_q;
		fmt_set  = 1'b0;
		dctl     = '0;
		d_waddr  = fidx_q;
		d_wfirst = wval;
		unique case (state_q)
			S_FMT: begin
				t_we    = 1'b1;
				t_waddr = i_q;
				t_wdata = fmt_val;
				if (i_q == LAST_I) begin
					fmt_set      = 1'b1;
					dctl.clr_all = 1'b1;
				end
			end
			S_DISP: begin
				if (op_q == fca_pkg::OP_CREATE && !found_q && freef_q) begin
					dctl.wr  = 1'b1;
					d_waddr  = free_q;
					d_wfirst = '0;
				end else if (op_q == fca_pkg::OP_REMOVE && found_q && first_q == '0) begin
					dctl.inval = 1'b1;
				end
			end
			S_HRD: t_raddr = '0;
			S_HGOT: t_raddr = t_rdata;
			S_NGOT: begin
				t_we    = 1'b1;
				t_waddr = '0;
				t_wdata = t_rdata;
			end
			S_ACLR: begin
				t_we    = 1'b1;
				t_waddr = alloc_q;
				t_wdata = '0;
			end
			S_DWR: dctl.wr = 1'b1;
			S_LINK: t_we = 1'b1;
			S_URD: t_raddr = '0;
			S_UGOT: begin
				t_we    = 1'b1;
				t_waddr = AW'(blk_q);
				t_wdata = t_rdata;
			end
			S_UHEAD: begin
				t_we    = 1'b1;
				t_waddr = '0;
				t_wdata = AW'(blk_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q <= fca_pkg::TABLE_BLOCKS_RST;
			bs_q <= fca_pkg::BLOCK_SIZE_RST;
		end else if (cfg_we) begin
			if (cfg_index == fca_pkg::REG_TABLE_BLOCKS) begin
				tb_q <= cfg_wdata[fca_pkg::TB_W-1:0];
			end else begin
				bs_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= fca_pkg::op_t'(operation);
			key_q <= file_key;
			blk_q <= block_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= '0;
			result_q <= '0;
			last_q   <= 1'b0;
			i_q      <= '0;
			idx_q    <= '0;
			fidx_q   <= '0;
			free_q   <= '0;
			found_q  <= 1'b0;
			freef_q  <= 1'b0;
			first_q  <= '0;
			b_q      <= '0;
			n_q      <= '0;
			alloc_q  <= '0;
			nb_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= fca_pkg::ST_OK;
						result_q <= '0;
						last_q   <= 1'b0;
						if (operation == fca_pkg::OP_FORMAT) begin
							i_q     <= '0;
							state_q <= S_FMT;
						end else if (operation == fca_pkg::OP_APPEND && data_length != bs_q) begin
							status_q <= fca_pkg::ST_BAD_LEN;
							done_q   <= 1'b1;
						end else begin
							idx_q   <= '0;
							found_q <= 1'b0;
							freef_q <= 1'b0;
							state_q <= S_DRD;
						end
					end
				end
				S_FMT: begin
					i_q <= i_q + AW'(1);
					if (i_q == LAST_I) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DRD: state_q <= S_DCMP;
				S_DCMP: begin
					// First matching valid entry and first free entry, in index order.
					if (d_rvalid && d_rkey == key_q && !found_q) begin
						found_q <= 1'b1;
						fidx_q  <= idx_q;
						first_q <= d_rfirst;
					end
					if (!d_rvalid && !freef_q) begin
						freef_q <= 1'b1;
						free_q  <= idx_q;
					end
					if (idx_q == LAST_D) begin
						state_q <= S_DISP;
					end else begin
						idx_q   <= idx_q + DW'(1);
						state_q <= S_DRD;
					end
				end
				S_DISP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (op_q == fca_pkg::OP_CREATE) begin
						if (found_q) begin
							status_q <= fca_pkg::ST_EXISTS;
						end else if (!freef_q) begin
							status_q <= fca_pkg::ST_DIR_FULL;
						end
					end else if (!found_q) begin
						status_q <= fca_pkg::ST_NOT_FOUND;
					end else begin
						case (op_q)
							fca_pkg::OP_REMOVE: begin
								if (first_q != '0) begin
									status_q <= fca_pkg::ST_NOT_EMPTY;
								end
							end
							fca_pkg::OP_FIRST: result_q <= fca_pkg::BLK_W'(first_q);
							fca_pkg::OP_APPEND: begin
								done_q  <= 1'b0;
								state_q <= S_HRD;
							end
							default: begin
								if (first_q == '0 || blk_bad) begin
									status_q <= fca_pkg::ST_NOT_OWNED;
								end else begin
									done_q  <= 1'b0;
									b_q     <= first_q;
									n_q     <= '0;
									state_q <= S_OWN;
								end
							end
						endcase
					end
				end
				S_HRD: state_q <= S_HGOT;
				S_HGOT: begin
					if (t_rdata == '0 || CW'(t_rdata) >= DB_C) begin
						status_q <= fca_pkg::ST_DISK_FULL;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						alloc_q <= t_rdata;
						state_q <= S_NGOT;
					end
				end
				S_NGOT: state_q <= S_ACLR;
				S_ACLR: begin
					if (first_q == '0) begin
						state_q <= S_DWR;
					end else begin
						b_q     <= first_q;
						n_q     <= '0;
						state_q <= S_WRD;
					end
				end
				S_DWR: begin
					if (op_q == fca_pkg::OP_APPEND) begin
						result_q <= fca_pkg::BLK_W'(alloc_q);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_URD;
					end
				end
				S_WRD: begin
					state_q <= (n_q == N_MAX) ? S_LINK : S_WGOT;
				end
				S_WGOT: begin
					// Stop on the block whose link matches the target.
					if (CW'(t_rdata) == tgt_c) begin
						state_q <= S_LINK;
					end else begin
						b_q     <= t_rdata;
						n_q     <= n_q + NW'(1);
						state_q <= S_WRD;
					end
				end
				S_LINK: begin
					if (op_q == fca_pkg::OP_APPEND) begin
						result_q <= fca_pkg::BLK_W'(alloc_q);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_URD;
					end
				end
				S_OWN: begin
					if (n_q == N_MAX || b_q == '0) begin
						status_q <= fca_pkg::ST_NOT_OWNED;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (CW'(b_q) == blk_c) begin
						// The read issued here fetches the queried block's link.
						state_q <= S_BGOT;
					end else begin
						state_q <= S_OGOT;
					end
				end
				S_OGOT: begin
					b_q     <= t_rdata;
					n_q     <= n_q + NW'(1);
					state_q <= S_OWN;
				end
				S_BGOT: begin
					nb_q <= t_rdata;
					if (op_q == fca_pkg::OP_UNLINK) begin
						if (CW'(first_q) == blk_c) begin
							state_q <= S_DWR;
						end else begin
							b_q     <= first_q;
							n_q     <= '0;
							state_q <= S_WRD;
						end
					end else begin
						last_q <= (t_rdata == '0);
						if (op_q == fca_pkg::OP_NEXT) begin
							result_q <= fca_pkg::BLK_W'(t_rdata);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_URD: state_q <= S_UGOT;
				S_UGOT: state_q <= S_UHEAD;
				S_UHEAD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign block_result = result_q;
	assign last_block   = last_q;

	a_done_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the sequencer is still at work");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != fca_pkg::ST_OK) |-> (block_result == '0 && !last_block))
		else $error("failed item carries a block number or end mark");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_block) |-> (status == fca_pkg::ST_OK && block_result == '0))
		else $error("end-of-chain mark with an error or a nonzero next block");

endmodule

>>> verif/tb.sv
// Self-checking testbench for fat_chain_allocator_unit: directed table, then random traffic.
// Holds its own model of the directory and the allocation table; depends on fca_pkg.
`timescale 1ns / 100ps

module tb;

	typedef struct {
		fca_pkg::status_t          st;
		logic [fca_pkg::BLK_W-1:0] res;
		logic                      last;
	} fs_result_t;

	typedef struct {
		fca_pkg::op_t              op;
		logic [fca_pkg::KEY_W-1:0] key;
		logic [fca_pkg::BLK_W-1:0] blk;
		logic [fca_pkg::LEN_W-1:0] len;
		bit                        typed;
		fs_result_t                want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [fca_pkg::OP_W-1:0] operation = '0;
	logic [fca_pkg::KEY_W-1:0] file_key = '0;
	logic [fca_pkg::BLK_W-1:0] block_index = '0;
	logic [fca_pkg::LEN_W-1:0] data_length = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [fca_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic busy, done, last_block;
	logic [fca_pkg::ST_W-1:0] status;
	logic [fca_pkg::BLK_W-1:0] block_result;

	// Typed expectation riding along with the directed item on the bus.
	bit row_typed = 1'b0;
	fs_result_t row_want;

	fat_chain_allocator_unit u_top (.*);

	// Model state.
	int unsigned tbl_blocks = 11;
	int unsigned blk_size = 128;
	bit dir_used [16];
	logic [fca_pkg::KEY_W-1:0] dir_name [16];
	int unsigned dir_head [16];
	int unsigned fat [256];

	fs_result_t pending_results [$];
	int errors = 0;
	int sender_idle_pct = 0;
	logic [fca_pkg::KEY_W-1:0] key_pool [20];

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned find_file(logic [fca_pkg::KEY_W-1:0] key);
		int unsigned f;
		f = 16;
		for (int i = 15; i >= 0; i--)
			if (dir_used[i] && dir_name[i] == key) f = i;
		return f;
	endfunction

	function automatic bit chain_has(int unsigned head, int unsigned blk);
		int unsigned b;
		b = head;
		if (head == 0 || blk == 0) return 1'b0;
		for (int n = 0; n < 256 && b != 0; n++) begin
			if (b == blk) return 1'b1;
			b = fat[b];
		end
		return 1'b0;
	endfunction

	function automatic fs_result_t fs_apply(fca_pkg::op_t op, logic [fca_pkg::KEY_W-1:0] key,
			logic [fca_pkg::BLK_W-1:0] blk, logic [fca_pkg::LEN_W-1:0] len);
		fs_result_t r;
		int unsigned f, b, alloc, first_blk;
		r.st = fca_pkg::ST_OK;
		r.res = '0;
		r.last = 1'b0;
		f = find_file(key);
		if (op == fca_pkg::OP_FORMAT) begin
			first_blk = tbl_blocks + 2;
			for (int i = 0; i < 16; i++) dir_used[i] = 1'b0;
			fat[0] = first_blk < 256 ? first_blk : 0;
			for (int i = 1; i < 256; i++)
				fat[i] = i < first_blk ? 1 : (i + 1 < 256 ? i + 1 : 0);
		end else if (op == fca_pkg::OP_CREATE) begin
			if (f < 16) begin
				r.st = fca_pkg::ST_EXISTS;
			end else begin
				f = 16;
				for (int i = 15; i >= 0; i--)
					if (!dir_used[i]) f = i;
				if (f == 16) begin
					r.st = fca_pkg::ST_DIR_FULL;
				end else begin
					dir_used[f] = 1'b1;
					dir_name[f] = key;
					dir_head[f] = 0;
				end
			end
		end else if (op == fca_pkg::OP_APPEND && len != blk_size) begin
			r.st = fca_pkg::ST_BAD_LEN;
		end else if (f == 16) begin
			r.st = fca_pkg::ST_NOT_FOUND;
		end else if (op == fca_pkg::OP_REMOVE) begin
			if (dir_head[f] != 0) r.st = fca_pkg::ST_NOT_EMPTY;
			else dir_used[f] = 1'b0;
		end else if (op == fca_pkg::OP_APPEND) begin
			alloc = fat[0];
			if (alloc == 0) begin
				r.st = fca_pkg::ST_DISK_FULL;
			end else begin
				fat[0] = fat[alloc];
				fat[alloc] = 0;
				if (dir_head[f] == 0) begin
					dir_head[f] = alloc;
				end else begin
					b = dir_head[f];
					for (int n = 0; n < 256 && fat[b] != 0; n++) b = fat[b];
					fat[b] = alloc;
				end
				r.res = fca_pkg::BLK_W'(alloc);
			end
		end else if (op == fca_pkg::OP_FIRST) begin
			r.res = fca_pkg::BLK_W'(dir_head[f]);
		end else if (!chain_has(dir_head[f], blk)) begin
			r.st = fca_pkg::ST_NOT_OWNED;
		end else if (op == fca_pkg::OP_UNLINK) begin
			if (dir_head[f] == blk) begin
				dir_head[f] = fat[blk];
			end else begin
				b = dir_head[f];
				for (int n = 0; n < 256 && fat[b] != blk; n++) b = fat[b];
				fat[b] = fat[blk];
			end
			fat[blk] = fat[0];
			fat[0] = blk;
		end else begin
			r.last = fat[blk] == 0;
			if (op == fca_pkg::OP_NEXT) r.res = fca_pkg::BLK_W'(fat[blk]);
		end
		return r;
	endfunction

	// Accepts items and register writes into the model and checks every result.
	always @(posedge clk) begin
		fs_result_t p, w;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == fca_pkg::REG_TABLE_BLOCKS)
					tbl_blocks = 32'(cfg_wdata[fca_pkg::TB_W-1:0]);
				else blk_size = 32'(cfg_wdata);
			end
			if (start && !busy) begin
				p = fs_apply(fca_pkg::op_t'(operation), file_key, block_index, data_length);
				pending_results = {pending_results, (row_typed ? row_want : p)};
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected, status %0d", $time, status);
					errors++;
				end else begin
					w = pending_results.pop_front();
					if (status !== w.st) begin
						$display("%0t: status expected %0d actual %0d", $time, w.st, status);
						errors++;
					end
					if (block_result !== w.res) begin
						$display("%0t: block_result expected %0d actual %0d",
							$time, w.res, block_result);
						errors++;
					end
					if (last_block !== w.last) begin
						$display("%0t: last_block expected %0d actual %0d",
							$time, w.last, last_block);
						errors++;
					end
				end
			end
		end
	end

	task automatic send_item(dir_row_t it);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= it.op;
		file_key <= it.key;
		block_index <= it.blk;
		data_length <= it.len;
		row_typed <= it.typed;
		row_want <= it.want;
		do @(posedge clk); while (busy);
	endtask

	// The extra edge lets the monitor record the item accepted at the last edge.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= fca_pkg::CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic dir_row_t mk(fca_pkg::op_t op, logic [fca_pkg::KEY_W-1:0] key,
			int unsigned blk, int unsigned len, bit typed = 1'b0,
			fca_pkg::status_t st = fca_pkg::ST_OK, int unsigned res = 0, bit last = 1'b0);
		dir_row_t r;
		r.op = op;
		r.key = key;
		r.blk = fca_pkg::BLK_W'(blk);
		r.len = fca_pkg::LEN_W'(len);
		r.typed = typed;
		r.want.st = st;
		r.want.res = fca_pkg::BLK_W'(res);
		r.want.last = last;
		return r;
	endfunction

	// Random item, mostly aimed at files in the pool and blocks they own.
	function automatic dir_row_t rand_item();
		dir_row_t it;
		int unsigned r, f, b, steps, pick;
		r = $urandom_range(0, 99);
		it = mk(fca_pkg::OP_FIRST, '0, 0, 0);
		if (r < 2) it.op = fca_pkg::OP_FORMAT;
		else if (r < 15) it.op = fca_pkg::OP_CREATE;
		else if (r < 22) it.op = fca_pkg::OP_REMOVE;
		else if (r < 50) it.op = fca_pkg::OP_APPEND;
		else if (r < 62) it.op = fca_pkg::OP_UNLINK;
		else if (r < 75) it.op = fca_pkg::OP_CHECK;
		else if (r < 88) it.op = fca_pkg::OP_NEXT;
		it.key = $urandom_range(0, 99) < 90 ? key_pool[$urandom_range(0, 19)]
			: {$urandom, $urandom};
		it.len = fca_pkg::LEN_W'($urandom_range(0, 4096));
		if (it.op == fca_pkg::OP_APPEND && $urandom_range(0, 9) != 0)
			it.len = fca_pkg::LEN_W'(blk_size);
		it.blk = fca_pkg::BLK_W'($urandom_range(0, 255));
		f = find_file(it.key);
		if (f < 16 && dir_head[f] != 0 && $urandom_range(0, 9) < 7) begin
			b = dir_head[f];
			steps = 1;
			while (steps < 256 && fat[b] != 0) begin
				b = fat[b];
				steps++;
			end
			pick = $urandom_range(0, steps - 1);
			b = dir_head[f];
			for (int n = 0; n < pick; n++) b = fat[b];
			it.blk = fca_pkg::BLK_W'(b);
		end
		return it;
	endfunction

	initial begin
		dir_row_t dir_rows [$];
		int unsigned tb_cfg [6];
		int unsigned bs_cfg [6];
		logic [fca_pkg::KEY_W-1:0] ka, kb;
		int total;
		tb_cfg = '{1, 64, 0, 11, 37, 64};
		bs_cfg = '{1, 4096, 0, 128, 0, 1};
		ka = 64'h0;
		kb = '1;
		key_pool[0] = ka;
		key_pool[1] = kb;
		for (int i = 2; i < 20; i++) key_pool[i] = {$urandom, $urandom};

		// Reset configuration: 11 table blocks, so the first free block is 13.
		dir_rows = '{
			mk(fca_pkg::OP_CREATE, ka, 0, 0, 1, fca_pkg::ST_OK),
			mk(fca_pkg::OP_APPEND, ka, 0, 128, 1, fca_pkg::ST_DISK_FULL),
			mk(fca_pkg::OP_FORMAT, ka, 0, 0, 1, fca_pkg::ST_OK),
			mk(fca_pkg::OP_FIRST,  ka, 0, 0, 1, fca_pkg::ST_NOT_FOUND),
			mk(fca_pkg::OP_CREATE, ka, 0, 0, 1, fca_pkg::ST_OK),
			mk(fca_pkg::OP_CREATE, ka, 0, 0, 1, fca_pkg::ST_EXISTS),
			mk(fca_pkg::OP_APPEND, ka, 0, 127, 1, fca_pkg::ST_BAD_LEN),
			mk(fca_pkg::OP_APPEND, kb, 0, 4096, 1, fca_pkg::ST_BAD_LEN),
			mk(fca_pkg::OP_APPEND, kb, 0, 128, 1, fca_pkg::ST_NOT_FOUND),
			mk(fca_pkg::OP_CHECK,  ka, 0, 0, 1, fca_pkg::ST_NOT_OWNED),
			mk(fca_pkg::OP_APPEND, ka, 0, 128, 1, fca_pkg::ST_OK, 13),
			mk(fca_pkg::OP_APPEND, ka, 0, 128, 1, fca_pkg::ST_OK, 14),
			mk(fca_pkg::OP_FIRST,  ka, 0, 0, 1, fca_pkg::ST_OK, 13),
			mk(fca_pkg::OP_CHECK,  ka, 13, 0, 1, fca_pkg::ST_OK, 0, 0),
			mk(fca_pkg::OP_NEXT,   ka, 13, 0, 1, fca_pkg::ST_OK, 14, 0),
			mk(fca_pkg::OP_NEXT,   ka, 14, 8191, 1, fca_pkg::ST_OK, 0, 1),
			mk(fca_pkg::OP_CHECK,  ka, 0, 0, 1, fca_pkg::ST_NOT_OWNED),
			mk(fca_pkg::OP_CHECK,  ka, 255, 0, 1, fca_pkg::ST_NOT_OWNED),
			mk(fca_pkg::OP_REMOVE, ka, 0, 0, 1, fca_pkg::ST_NOT_EMPTY),
			mk(fca_pkg::OP_UNLINK, ka, 13, 0, 1, fca_pkg::ST_OK),
			mk(fca_pkg::OP_FIRST,  ka, 0, 0, 1, fca_pkg::ST_OK, 14),
			mk(fca_pkg::OP_UNLINK, ka, 14, 0, 1, fca_pkg::ST_OK),
			mk(fca_pkg::OP_REMOVE, ka, 0, 0, 1, fca_pkg::ST_OK),
			mk(fca_pkg::OP_CREATE, kb, 255, 0, 1, fca_pkg::ST_OK),
			mk(fca_pkg::OP_APPEND, kb, 0, 128)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (dir_rows[i]) send_item(dir_rows[i]);

		total = 0;
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_reg(fca_pkg::REG_TABLE_BLOCKS,
				tb_cfg[ph] != 0 ? tb_cfg[ph] : $urandom_range(1, 64));
			write_reg(fca_pkg::REG_BLOCK_SIZE,
				bs_cfg[ph] != 0 ? bs_cfg[ph] : $urandom_range(1, 4096));
			send_item(mk(fca_pkg::OP_FORMAT, '0, 0, 0));
			for (int n = 0; n < 290; n++) begin
				sender_idle_pct = total < 580 ? 29 : (total < 1160 ? 54 : 0);
				if (n == 150) wait_drained();
				send_item(rand_item());
				total++;
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
